[hw/rtl/slfc_pkg.sv]
// Shared types, codes and helpers for the supply link frame controller.
package slfc_pkg;

  localparam int RES_MAX = 3;
  localparam int CNT_W   = $clog2(RES_MAX + 1);

  // request kinds
  localparam logic [1:0] REQ_RX_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_SEND    = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PING_PERIOD   = 2'd0;
  localparam logic [1:0] REG_ONLINE_WINDOW = 2'd1;
  localparam logic [1:0] REG_CHECKSUM_BIAS = 2'd2;

  localparam logic [15:0] PING_PERIOD_RST   = 16'd33333;
  localparam logic [15:0] ONLINE_WINDOW_RST = 16'd65500;
  localparam logic [7:0]  CHECKSUM_BIAS_RST = 8'd5;

  // link byte codes
  localparam logic [7:0] WRITE_CODE    = 8'h42;
  localparam logic [7:0] CODE_ACTIVATE = 8'h1A;
  localparam logic [7:0] CODE_ENABLE   = 8'h2C;
  localparam logic [7:0] CODE_OK       = 8'hAC;
  localparam logic [7:0] CODE_PING     = 8'h15;
  localparam logic [7:0] CODE_PONG     = 8'h16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] frame_status;
    logic       activated;
    logic       enabled;
    logic       online;
  } out_t;

  typedef out_t [RES_MAX-1:0] burst_t;

  // load request from the request decode into the result queue
  typedef struct packed {
    logic             push;
    logic [CNT_W-1:0] count;
  } load_t;

  // three-byte outgoing frame: write code, command, checksum
  function automatic burst_t make_frame(input logic [7:0] code, input logic [7:0] bias,
                                        input logic online, input logic act,
                                        input logic ena);
    burst_t     f;
    logic [7:0] csum;
    csum = WRITE_CODE + code - bias;
    f[0] = '{tx_valid: 1'b1, tx_byte: WRITE_CODE, last: 1'b0, frame_status: ST_NONE,
             activated: act, enabled: ena, online: online};
    f[1] = '{tx_valid: 1'b1, tx_byte: code, last: 1'b0, frame_status: ST_NONE,
             activated: act, enabled: ena, online: online};
    f[2] = '{tx_valid: 1'b1, tx_byte: csum, last: 1'b1, frame_status: ST_NONE,
             activated: act, enabled: ena, online: online};
    return f;
  endfunction

endpackage

[hw/rtl/slfc_out_queue.sv]
// Result queue: holds one request's results, sent out one per cycle unless stalled.
module slfc_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  slfc_pkg::load_t        load,
  input  slfc_pkg::burst_t       load_items,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slfc_pkg::out_t         out_data
);

  slfc_pkg::burst_t                 items_r, items_nxt;
  logic [slfc_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = items_r[0];
  assign pop       = out_valid && out_ready;
  // room for a new burst once the queue drains this cycle
  assign can_load  = (cnt_r == '0) || ((cnt_r == slfc_pkg::CNT_W'(1)) && out_ready);

  always_comb begin
    items_nxt = items_r;
    cnt_nxt   = cnt_r;
    if (load.push) begin
      items_nxt = load_items;
      cnt_nxt   = load.count;
    end else if (pop) begin
      for (int i = 0; i < slfc_pkg::RES_MAX - 1; i++) begin
        items_nxt[i] = items_r[i+1];
      end
      cnt_nxt = cnt_r - slfc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    items_r <= items_nxt;
  end

endmodule

[hw/rtl/supply_link_frame_controller.sv]
// Supply link frame controller: frame receive check, command and ping frame send.
// The first result of a request is shown the cycle after it is taken. Results
// leave one per cycle unless stalled; byte and plain tick requests give one result,
// send and ping ticks give three, so throughput is one request per result slot.
// A new request is taken while the last pending result is being taken.
// Synchronous active-low reset clears counters, flags and receive state, and loads
// the config registers with their defaults.
module supply_link_frame_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  slfc_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output slfc_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  // configuration registers
  logic [15:0] ping_period_r;
  logic [15:0] online_window_r;
  logic [7:0]  bias_r;

  // link state
  logic [7:0]  rx0_r, rx0_nxt;
  logic [7:0]  rx1_r, rx1_nxt;
  logic [1:0]  rx_pos_r, rx_pos_nxt;
  logic [15:0] ping_cnt_r, ping_cnt_nxt;
  logic [15:0] win_cnt_r, win_cnt_nxt;
  logic        act_r, act_nxt;
  logic        ena_r, ena_nxt;
  logic        pong_r, pong_nxt;

  logic              in_acc;
  logic              can_load;
  logic [16:0]       ping_inc, win_inc;
  logic              ping_fire, win_fire;
  logic [8:0]        sum_ab, sum_rhs;
  logic              frame_good;
  logic              tick_online;
  slfc_pkg::load_t   load;
  slfc_pkg::burst_t  items;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign in_acc    = in_valid && in_ready;

  // counters compare one bit wider so a full count always fires
  assign ping_inc  = {1'b0, ping_cnt_r} + 17'd1;
  assign win_inc   = {1'b0, win_cnt_r} + 17'd1;
  assign ping_fire = ping_inc >= {1'b0, ping_period_r};
  assign win_fire  = win_inc >= {1'b0, online_window_r};

  // first + second - bias == third, rearranged to avoid negative values
  assign sum_ab     = {1'b0, rx0_r} + {1'b0, rx1_r};
  assign sum_rhs    = {1'b0, in_data.data_byte} + {1'b0, bias_r};
  assign frame_good = (sum_ab == sum_rhs);

  // at window end report pong, which a ping on this same tick has just cleared
  assign tick_online = win_fire ? (pong_r && !ping_fire) : 1'b1;

  always_comb begin
    rx0_nxt      = rx0_r;
    rx1_nxt      = rx1_r;
    rx_pos_nxt   = rx_pos_r;
    ping_cnt_nxt = ping_cnt_r;
    win_cnt_nxt  = win_cnt_r;
    act_nxt      = act_r;
    ena_nxt      = ena_r;
    pong_nxt     = pong_r;
    items        = '0;
    load.count   = '0;

    case (in_data.req_type)
      slfc_pkg::REQ_RX_BYTE: begin
        items[0].frame_status = slfc_pkg::ST_NONE;
        if (rx_pos_r == 2'd0) begin
          rx0_nxt    = in_data.data_byte;
          rx_pos_nxt = 2'd1;
        end else if (rx_pos_r == 2'd1) begin
          rx1_nxt    = in_data.data_byte;
          rx_pos_nxt = 2'd2;
        end else begin
          rx_pos_nxt = 2'd0;
          if (frame_good) begin
            items[0].frame_status = slfc_pkg::ST_GOOD;
            if (rx0_r == slfc_pkg::CODE_ACTIVATE) begin
              act_nxt = (rx1_r == slfc_pkg::CODE_OK);
            end else if (rx0_r == slfc_pkg::CODE_ENABLE) begin
              ena_nxt  = (rx1_r == slfc_pkg::CODE_OK);
              pong_nxt = 1'b1;
            end else if (rx0_r == slfc_pkg::CODE_OK) begin
              pong_nxt = (rx1_r == slfc_pkg::CODE_PONG);
            end
          end else begin
            items[0].frame_status = slfc_pkg::ST_BAD;
          end
        end
        items[0].last      = 1'b1;
        items[0].online    = 1'b1;
        items[0].activated = act_nxt;
        items[0].enabled   = ena_nxt;
        load.count         = slfc_pkg::CNT_W'(1);
      end
      slfc_pkg::REQ_TICK: begin
        ping_cnt_nxt = ping_fire ? 16'd0 : ping_inc[15:0];
        win_cnt_nxt  = win_fire  ? 16'd0 : win_inc[15:0];
        if (ping_fire) begin
          pong_nxt   = 1'b0;
          items      = slfc_pkg::make_frame(slfc_pkg::CODE_PING, bias_r, tick_online,
                                            act_r, ena_r);
          load.count = slfc_pkg::CNT_W'(slfc_pkg::RES_MAX);
        end else begin
          items[0].last      = 1'b1;
          items[0].online    = tick_online;
          items[0].activated = act_r;
          items[0].enabled   = ena_r;
          load.count         = slfc_pkg::CNT_W'(1);
        end
      end
      slfc_pkg::REQ_SEND: begin
        items      = slfc_pkg::make_frame(in_data.data_byte, bias_r, 1'b1, act_r, ena_r);
        load.count = slfc_pkg::CNT_W'(slfc_pkg::RES_MAX);
      end
      default: begin
        // unused request kind: taken, no results, no state change
        load.count = '0;
      end
    endcase

    load.push = in_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_period_r   <= slfc_pkg::PING_PERIOD_RST;
      online_window_r <= slfc_pkg::ONLINE_WINDOW_RST;
      bias_r          <= slfc_pkg::CHECKSUM_BIAS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slfc_pkg::REG_PING_PERIOD:   ping_period_r   <= cfg_data;
        slfc_pkg::REG_ONLINE_WINDOW: online_window_r <= cfg_data;
        slfc_pkg::REG_CHECKSUM_BIAS: bias_r          <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx0_r      <= '0;
      rx1_r      <= '0;
      rx_pos_r   <= '0;
      ping_cnt_r <= '0;
      win_cnt_r  <= '0;
      act_r      <= 1'b0;
      ena_r      <= 1'b0;
      pong_r     <= 1'b0;
    end else if (in_acc) begin
      rx0_r      <= rx0_nxt;
      rx1_r      <= rx1_nxt;
      rx_pos_r   <= rx_pos_nxt;
      ping_cnt_r <= ping_cnt_nxt;
      win_cnt_r  <= win_cnt_nxt;
      act_r      <= act_nxt;
      ena_r      <= ena_nxt;
      pong_r     <= pong_nxt;
    end
  end

  // result register and burst sequencing
  slfc_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_items (items),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[hw/rtl/slfc_checker.sv]
// Port-level checks for the supply link frame controller, bound to the top level.
module slfc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input slfc_pkg::in_t    in_data,
  input logic             out_valid,
  input logic             out_ready,
  input slfc_pkg::out_t   out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an empty result side never blocks a request
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with no pending result");

  // a send request starts its frame with the write code next cycle
  a_send_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.req_type == slfc_pkg::REQ_SEND) |=>
      out_valid && out_data.tx_valid && !out_data.last &&
      (out_data.tx_byte == slfc_pkg::WRITE_CODE))
    else $error("send frame did not start with write code");

  // a received byte gives exactly one non-transmit result next cycle
  a_rx_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.req_type == slfc_pkg::REQ_RX_BYTE) |=>
      out_valid && out_data.last && !out_data.tx_valid)
    else $error("received byte result malformed");

  // results that carry no byte are always single
  a_notx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.last &&
      (out_data.tx_byte == 8'd0))
    else $error("non-transmit result inside a burst");

endmodule

bind supply_link_frame_controller slfc_checker u_slfc_checker (.*);
